[design/assert_macros.svh]
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the decimating filter checkers.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FIRD3_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FIRD3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/fird3_pkg.sv]
// -----------------------------------------------------------------------------
// fird3_pkg
// Widths, coefficients and types shared by the decimating filter modules.
// -----------------------------------------------------------------------------
`default_nettype none

package fird3_pkg;

    localparam int SmpW      = 16;
    localparam int NumTaps   = 13;
    localparam int HistDepth = NumTaps - 1;
    localparam int CenterTap = (NumTaps - 1) / 2;
    localparam int FracBits  = 15;
    localparam int AccW      = 32;
    localparam int QuotW     = AccW - FracBits;

    // Q1.15 low-pass coefficients, symmetric about the center tap.
    localparam logic signed [SmpW-1:0] Coef [NumTaps] = '{
        -16'sd387, -16'sd829, -16'sd423, 16'sd1878, 16'sd5751, 16'sd8674, 16'sd9981,
        16'sd8674, 16'sd5751, 16'sd1878, -16'sd423, -16'sd829, -16'sd387
    };

    localparam logic signed [QuotW-1:0] SatMax = QuotW'(32767);
    localparam logic signed [QuotW-1:0] SatMin = -QuotW'(32768);

    typedef logic [SmpW-1:0] t_smp;
    typedef logic [NumTaps-1:0][SmpW-1:0] t_taps;

endpackage

`default_nettype wire

[design/fird3_mac.sv]
// -----------------------------------------------------------------------------
// fird3_mac
// One output of the 13-tap symmetric filter: pre-add, multiply, sum, round
// toward zero and saturate to 16 bits.
// -----------------------------------------------------------------------------
`default_nettype none

module fird3_mac (
    input  wire fird3_pkg::t_taps i_taps,
    output fird3_pkg::t_smp       o_result
);

    always_comb begin
        logic signed [fird3_pkg::SmpW:0]       pre;
        logic signed [fird3_pkg::AccW-1:0]     prod;
        logic signed [fird3_pkg::AccW-1:0]     acc;
        logic signed [fird3_pkg::QuotW-1:0]    quot;
        acc = '0;
        // Mirrored taps share a coefficient, so add the samples first.
        for (int t = 0; t < fird3_pkg::CenterTap; t++) begin
            pre  = $signed({i_taps[t][fird3_pkg::SmpW-1], i_taps[t]})
                 + $signed({i_taps[fird3_pkg::NumTaps-1-t][fird3_pkg::SmpW-1],
                            i_taps[fird3_pkg::NumTaps-1-t]});
            prod = $signed({{(fird3_pkg::AccW-fird3_pkg::SmpW-1){pre[fird3_pkg::SmpW]}}, pre})
                 * $signed({{(fird3_pkg::AccW-fird3_pkg::SmpW){fird3_pkg::Coef[t][fird3_pkg::SmpW-1]}},
                            fird3_pkg::Coef[t]});
            acc  = acc + prod;
        end
        prod = $signed({{(fird3_pkg::AccW-fird3_pkg::SmpW){
                          i_taps[fird3_pkg::CenterTap][fird3_pkg::SmpW-1]}},
                        i_taps[fird3_pkg::CenterTap]})
             * $signed({{(fird3_pkg::AccW-fird3_pkg::SmpW){
                          fird3_pkg::Coef[fird3_pkg::CenterTap][fird3_pkg::SmpW-1]}},
                        fird3_pkg::Coef[fird3_pkg::CenterTap]});
        acc  = acc + prod;

        // The shift floors; a negative sum with a nonzero fraction steps back up.
        quot = acc[fird3_pkg::AccW-1:fird3_pkg::FracBits];
        if (acc[fird3_pkg::AccW-1] && (acc[fird3_pkg::FracBits-1:0] != '0)) begin
            quot = quot + fird3_pkg::QuotW'(1);
        end

        if (quot > fird3_pkg::SatMax) begin
            o_result = fird3_pkg::SatMax[fird3_pkg::SmpW-1:0];
        end else if (quot < fird3_pkg::SatMin) begin
            o_result = fird3_pkg::SatMin[fird3_pkg::SmpW-1:0];
        end else begin
            o_result = quot[fird3_pkg::SmpW-1:0];
        end
    end

endmodule

`default_nettype wire

[design/fir_decimate_by_three.sv]
// -----------------------------------------------------------------------------
// fir_decimate_by_three
// 3:1 decimating 13-tap low-pass filter over framed 16-bit audio.
// -----------------------------------------------------------------------------
// Usage:
//   Input stream: tdata = sample, tlast = last sample of a frame,
//   tuser[0] = first sample of a frame, tuser[1] = bypass.
//   Output stream: tdata = result sample, tlast = last result of the input
//   transfer that caused it, tuser[0] = final result of the frame.
//   A filtered result appears for every third input once the window is full;
//   the last sample of a frame flushes up to two owed results. A bypassed
//   sample yields exactly one result, the sample itself.
//   An input's results pass through the window stage, then the result buffer.
//   Throughput is one input per cycle with a ready receiver while each input
//   yields at most one result; one that yields two holds the input side
//   longer, set by the single output port of the two-entry result buffer.
//   Reset clears the history, the counters and all valid state. When the
//   receiver stalls, results wait in the buffer, one item waits in the
//   window stage, and tready then drops until room opens.
// -----------------------------------------------------------------------------
`default_nettype none

module fir_decimate_by_three (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_axis_tvalid,
    output      logic                      o_s_axis_tready,
    input  wire logic [fird3_pkg::SmpW-1:0] i_s_axis_tdata,  // [15:0] sample
    input  wire logic                      i_s_axis_tlast,  // frame_last
    input  wire logic [1:0]                i_s_axis_tuser,  // [0] frame_first, [1] bypass
    output      logic                      o_m_axis_tvalid,
    input  wire logic                      i_m_axis_tready,
    output      logic [fird3_pkg::SmpW-1:0] o_m_axis_tdata,  // [15:0] out_sample
    output      logic                      o_m_axis_tlast,  // run_last
    output      logic [0:0]                o_m_axis_tuser   // [0] frame_end
);

    localparam logic [2:0] WarmFull = 3'd6;

    // Frame state.
    fird3_pkg::t_smp r_hist [fird3_pkg::HistDepth];
    logic [1:0]      r_phase;
    logic [2:0]      r_warm;

    // Window stage.
    logic              r_s1_valid;
    logic              r_s1_two;
    logic              r_s1_byp;
    logic              r_s1_last;
    fird3_pkg::t_smp   r_s1_sample;
    fird3_pkg::t_taps  r_s1_taps0;
    fird3_pkg::t_taps  r_s1_taps1;

    // Result buffer, entry 0 is the head.
    fird3_pkg::t_smp r_ob_data [2];
    logic [1:0]      r_ob_rl;
    logic [1:0]      r_ob_fe;
    logic [1:0]      r_ob_cnt;

    logic            s_xfer;
    logic            m_xfer;
    logic            s1_move;
    logic            first;
    logic            last;
    logic            byp;
    logic [1:0]      phase_eff;
    logic [2:0]      warm_eff;
    fird3_pkg::t_smp win [fird3_pkg::NumTaps];
    logic            has0;
    logic            has1;
    logic [2:0]      back0;
    logic [2:0]      back1;
    fird3_pkg::t_taps n_taps0;
    fird3_pkg::t_taps n_taps1;
    fird3_pkg::t_smp mac0;
    fird3_pkg::t_smp mac1;

    assign first = i_s_axis_tuser[0];
    assign byp   = i_s_axis_tuser[1];
    assign last  = i_s_axis_tlast;

    assign m_xfer  = o_m_axis_tvalid && i_m_axis_tready;
    assign s1_move = r_s1_valid && ((r_ob_cnt == 2'd0) || ((r_ob_cnt == 2'd1) && m_xfer));
    assign o_s_axis_tready = !r_s1_valid || s1_move;
    assign s_xfer  = i_s_axis_tvalid && o_s_axis_tready;

    // A frame start sees an empty history and zeroed counters.
    assign phase_eff = first ? 2'd0 : r_phase;
    assign warm_eff  = first ? 3'd0 : r_warm;

    always_comb begin
        win[0] = i_s_axis_tdata;
        for (int i = 0; i < fird3_pkg::HistDepth; i++) begin
            win[i + 1] = first ? '0 : r_hist[i];
        end
    end

    // Which centers are due: the regular output at phase zero, plus the
    // outputs owed at the end of a frame if enough samples have been seen.
    always_comb begin
        has0  = 1'b0;
        has1  = 1'b0;
        back0 = 3'd6;
        back1 = 3'd3;
        case (phase_eff)
            2'd0: begin
                if (warm_eff == WarmFull) begin
                    has0 = 1'b1;
                    if (last) begin
                        has1 = 1'b1;
                    end
                end else if (last && (warm_eff >= 3'd3)) begin
                    has0  = 1'b1;
                    back0 = 3'd3;
                end
            end
            2'd1: begin
                if (last && (warm_eff >= 3'd4)) begin
                    has0  = 1'b1;
                    back0 = 3'd4;
                end
            end
            2'd2: begin
                back1 = 3'd2;
                if (last && (warm_eff >= 3'd5)) begin
                    has0  = 1'b1;
                    back0 = 3'd5;
                    has1  = 1'b1;
                end else if (last && (warm_eff >= 3'd2)) begin
                    has0  = 1'b1;
                    back0 = 3'd2;
                end
            end
            default: begin
                has0 = 1'b0;
            end
        endcase
    end

    // Align each window to its center; samples past the newest read as zero.
    always_comb begin
        logic [4:0] sum0;
        logic [4:0] sum1;
        logic [4:0] m0;
        logic [4:0] m1;
        sum0 = 5'(back0) + 5'd6;
        sum1 = 5'(back1) + 5'd6;
        for (int t = 0; t < fird3_pkg::NumTaps; t++) begin
            m0 = sum0 - 5'(t);
            m1 = sum1 - 5'(t);
            n_taps0[t] = (5'(t) <= sum0) ? win[m0[3:0]] : '0;
            n_taps1[t] = (5'(t) <= sum1) ? win[m1[3:0]] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_warm  <= '0;
            for (int i = 0; i < fird3_pkg::HistDepth; i++) begin
                r_hist[i] <= '0;
            end
        end else if (s_xfer) begin
            if (last) begin
                r_phase <= '0;
                r_warm  <= '0;
                for (int i = 0; i < fird3_pkg::HistDepth; i++) begin
                    r_hist[i] <= '0;
                end
            end else begin
                r_phase <= (phase_eff >= 2'd2) ? 2'd0 : phase_eff + 2'd1;
                r_warm  <= (warm_eff < WarmFull) ? warm_eff + 3'd1 : WarmFull;
                for (int i = 0; i < fird3_pkg::HistDepth; i++) begin
                    r_hist[i] <= win[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_xfer) begin
            r_s1_valid <= byp || has0;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_s1_two    <= !byp && has1;
            r_s1_byp    <= byp;
            r_s1_last   <= last;
            r_s1_sample <= i_s_axis_tdata;
            r_s1_taps0  <= n_taps0;
            r_s1_taps1  <= n_taps1;
        end
    end

    fird3_mac u_mac0 (
        .i_taps   (r_s1_taps0),
        .o_result (mac0)
    );

    fird3_mac u_mac1 (
        .i_taps   (r_s1_taps1),
        .o_result (mac1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_cnt <= '0;
        end else if (s1_move) begin
            r_ob_cnt <= r_s1_two ? 2'd2 : 2'd1;
        end else if (m_xfer) begin
            r_ob_cnt <= r_ob_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_ob_data[0] <= r_s1_byp ? r_s1_sample : mac0;
            r_ob_data[1] <= mac1;
            r_ob_rl      <= {1'b1, !r_s1_two};
            r_ob_fe      <= {r_s1_last, !r_s1_two && r_s1_last};
        end else if (m_xfer) begin
            r_ob_data[0] <= r_ob_data[1];
            r_ob_rl[0]   <= r_ob_rl[1];
            r_ob_fe[0]   <= r_ob_fe[1];
        end
    end

    assign o_m_axis_tvalid   = (r_ob_cnt != 2'd0);
    assign o_m_axis_tdata    = r_ob_data[0];
    assign o_m_axis_tlast    = r_ob_rl[0];
    assign o_m_axis_tuser[0] = r_ob_fe[0];

endmodule

`default_nettype wire

[design/fird3_chk.sv]
// -----------------------------------------------------------------------------
// fird3_chk
// Port-level checks for the decimating filter, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fird3_chk (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_s_axis_tready,
    input wire logic                       o_m_axis_tvalid,
    input wire logic                       i_m_axis_tready,
    input wire logic [fird3_pkg::SmpW-1:0] o_m_axis_tdata,
    input wire logic                       o_m_axis_tlast,
    input wire logic [0:0]                 o_m_axis_tuser
);

    // A stalled result keeps its valid and its contents.
    `FIRD3_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
            && $stable(o_m_axis_tuser), "output changed while stalled")

    // The end of a frame is always the last result of its transfer.
    `FIRD3_ASSERT_NOW(a_fe_is_last, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tlast,
        "frame end without run end")

    // The second result of a pair is already buffered behind the first.
    `FIRD3_ASSERT_NEXT(a_pair_follows, i_clk, i_rst_n,
        o_m_axis_tvalid && !o_m_axis_tlast, o_m_axis_tvalid,
        "second result of a pair missing")

    // The input side only backs up when results are waiting.
    `FIRD3_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n,
        !o_s_axis_tready, o_m_axis_tvalid,
        "input stalled with no result pending")

endmodule

bind fir_decimate_by_three fird3_chk u_fird3_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

[tb/tb_fir_decimate_by_three.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_fir_decimate_by_three
// Self-checking bench for the 3:1 decimating 13-tap low-pass filter.
// A behavioral copy of the filter predicts every result from the accepted
// input transfers. Directed frames cover short frames, full-scale saturation,
// a missing first mark and bypass toggling inside a frame. Random framed
// traffic follows, with random gaps on the input and random stalls on the
// output, apart from one back-to-back stretch without either.
// -----------------------------------------------------------------------------

module tb_fir_decimate_by_three;

    localparam int HIST_LEN = 12;
    localparam int TAP_COUNT = 13;
    localparam int FULL_WINDOW = 6;
    localparam logic signed [15:0] MAX_SAMPLE = 16'sh7FFF;
    localparam logic signed [15:0] MIN_SAMPLE = 16'sh8000;

    // Q1.15 low-pass taps, symmetric about the center.
    localparam int LOWPASS_TAPS [TAP_COUNT] = '{
        -387, -829, -423, 1878, 5751, 8674, 9981, 8674, 5751, 1878, -423, -829, -387
    };

    typedef struct packed {
        logic [15:0] smp;
        logic        run_last;
        logic        frame_end;
    } result_t;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_s_axis_tvalid = 1'b0;
    logic                        o_s_axis_tready;
    logic [fird3_pkg::SmpW-1:0]  i_s_axis_tdata = '0;   // [15:0] sample
    logic                        i_s_axis_tlast = 1'b0;  // frame_last
    logic [1:0]                  i_s_axis_tuser = '0;    // [0] frame_first, [1] bypass
    logic                        o_m_axis_tvalid;
    logic                        i_m_axis_tready = 1'b0;
    logic [fird3_pkg::SmpW-1:0]  o_m_axis_tdata;         // [15:0] out_sample
    logic                        o_m_axis_tlast;         // run_last
    logic [0:0]                  o_m_axis_tuser;         // [0] frame_end

    fir_decimate_by_three u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Filter state mirrored from the accepted input transfers.
    logic signed [15:0] sample_hist [HIST_LEN];
    logic signed [15:0] window [TAP_COUNT];
    logic [1:0]         dec_phase;
    logic [2:0]         warm_count;

    result_t expected_results [$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      results_checked = 0;
    int      frames_closed = 0;
    bit      pace_gaps = 1'b1;
    bit      rx_stalls = 1'b1;
    int      rx_hold = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb_fir_decimate_by_three: FAIL");
        $finish;
    end

    function automatic void clear_frame_state();
        for (int i = 0; i < HIST_LEN; i++) begin
            sample_hist[i] = '0;
        end
        dec_phase = '0;
        warm_count = '0;
    endfunction

    // Sum over the window centered `back` samples before the newest one,
    // truncated toward zero and saturated to 16 bits.
    function automatic logic [15:0] lowpass_at(input int back);
        longint acc;
        int     j;
        acc = 0;
        for (int t = 0; t < TAP_COUNT; t++) begin
            j = back - t + 6;
            if (j >= 0 && j < TAP_COUNT) begin
                acc += longint'(LOWPASS_TAPS[t]) * longint'(window[j]);
            end
        end
        acc = acc / 32768;
        if (acc > 32767) begin
            acc = 32767;
        end
        if (acc < -32768) begin
            acc = -32768;
        end
        return acc[15:0];
    endfunction

    function automatic void predict_decimator(input logic [15:0] smp, input logic first,
                                              input logic last, input logic byp);
        int      backs [3];
        int      cand [2];
        int      n_back;
        int      n_cand;
        result_t r;
        if (first) begin
            clear_frame_state();
        end
        window[0] = smp;
        for (int i = 0; i < HIST_LEN; i++) begin
            window[i + 1] = sample_hist[i];
        end

        n_back = 0;
        if (warm_count >= FULL_WINDOW && dec_phase == 2'd0) begin
            backs[n_back] = 6;
            n_back++;
        end
        // The last sample flushes the outputs still owed; a young frame only
        // owes those whose center it has already reached.
        if (last) begin
            n_cand = (dec_phase == 2'd2) ? 2 : ((dec_phase == 2'd3) ? 0 : 1);
            cand[0] = (dec_phase == 2'd0) ? 3 : ((dec_phase == 2'd1) ? 4 : 5);
            cand[1] = 2;
            for (int i = 0; i < n_cand; i++) begin
                if (warm_count >= FULL_WINDOW || cand[i] <= int'(warm_count)) begin
                    backs[n_back] = cand[i];
                    n_back++;
                end
            end
        end

        if (byp) begin
            r.smp = smp;
            r.run_last = 1'b1;
            r.frame_end = last;
            expected_results.push_back(r);
        end else begin
            for (int i = 0; i < n_back && i < 2; i++) begin
                r.smp = lowpass_at(backs[i]);
                r.run_last = (i == n_back - 1) || (i == 1);
                r.frame_end = r.run_last && last;
                expected_results.push_back(r);
            end
        end

        for (int i = 0; i < HIST_LEN; i++) begin
            sample_hist[i] = window[i];
        end
        if (last) begin
            clear_frame_state();
        end else begin
            dec_phase = (dec_phase >= 2'd2) ? 2'd0 : dec_phase + 2'd1;
            if (warm_count < FULL_WINDOW) begin
                warm_count = warm_count + 3'd1;
            end
        end
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] random_sample();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0: return MAX_SAMPLE;
            1: return MIN_SAMPLE;
            2: return 16'(int'($urandom_range(0, 200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    // Called at a rising edge; returns at the rising edge of acceptance or
    // at the end of the idle gap that follows it.
    task automatic send_item(input logic [15:0] smp, input logic first, input logic last,
                             input logic byp);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= smp;
        i_s_axis_tlast <= last;
        i_s_axis_tuser <= {byp, first};
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        predict_decimator(smp, first, last, byp);
        items_sent++;
        if (last) begin
            frames_closed++;
        end
        gap = pace_gaps ? idle_gap() : 0;
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_short_frames();
        send_item(16'sd1200, 1'b1, 1'b1, 1'b0);
        send_item(-16'sd5000, 1'b1, 1'b0, 1'b0);
        send_item(16'sd7000, 1'b0, 1'b1, 1'b0);
    endtask

    // A positive full-scale frame saturates high; the negative one that
    // follows has no first mark and must still start from a clean history.
    task automatic test_full_scale();
        for (int k = 0; k < 7; k++) begin
            send_item(MAX_SAMPLE, k == 0, k == 6, 1'b0);
        end
        for (int k = 0; k < 7; k++) begin
            send_item(MIN_SAMPLE, 1'b0, k == 6, 1'b0);
        end
    endtask

    task automatic test_bypass_mix();
        logic [5:0] byp_pattern;
        byp_pattern = 6'b100101;
        for (int k = 0; k < 6; k++) begin
            send_item(random_sample(), k == 0, k == 5, byp_pattern[k]);
        end
    endtask

    task automatic test_random_traffic(input int n_items);
        int   sent;
        int   len;
        logic first_mark;
        logic end_mark;
        logic frame_byp;
        logic byp;
        logic first;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 14);
            first_mark = ($urandom_range(0, 7) != 0);
            end_mark = ($urandom_range(0, 15) != 0);
            frame_byp = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < len; k++) begin
                byp = ($urandom_range(0, 19) == 0) ? ~frame_byp : frame_byp;
                // Stray first marks inside a frame restart it mid-stream.
                first = (first_mark && k == 0) || ($urandom_range(0, 39) == 0);
                send_item(random_sample(), first, end_mark && k == len - 1, byp);
            end
            sent += len;
        end
    endtask

    task automatic test_back_to_back(input int n_items);
        pace_gaps = 1'b0;
        rx_stalls = 1'b0;
        test_random_traffic(n_items);
        pace_gaps = 1'b1;
        rx_stalls = 1'b1;
    endtask

    // Receiver: ready and stall stretches of random length, mostly short.
    always @(posedge i_clk) begin
        if (!rx_stalls) begin
            i_m_axis_tready <= 1'b1;
            rx_hold <= 0;
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (!i_m_axis_tready) begin
            i_m_axis_tready <= 1'b1;
            rx_hold <= $urandom_range(0, 8);
        end else begin
            i_m_axis_tready <= 1'b0;
            rx_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
        end
    end

    function automatic void flag_mismatch(input string what, input result_t want,
                                          input result_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected sample %0d last %b end %b, got sample %0d last %b end %b",
                     $time, what, $signed(want.smp), want.run_last, want.frame_end,
                     $signed(got.smp), got.run_last, got.frame_end);
        end
    endfunction

    always @(posedge i_clk) begin
        result_t got;
        result_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = '{smp: o_m_axis_tdata, run_last: o_m_axis_tlast, frame_end: o_m_axis_tuser[0]};
            results_checked++;
            if (expected_results.size() == 0) begin
                flag_mismatch("result with none expected", '0, got);
            end else begin
                want = expected_results.pop_front();
                if (got.smp !== want.smp || got.run_last !== want.run_last
                        || got.frame_end !== want.frame_end) begin
                    flag_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    initial begin
        clear_frame_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_frames();
        test_full_scale();
        test_bypass_mix();
        test_random_traffic(300);
        wait_idle();
        test_back_to_back(100);
        test_random_traffic(300);

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d samples in %0d closed frames; checked %0d results.",
                 items_sent, frames_closed, results_checked);
        $display("Covered short and full-scale frames, missing first marks, bypass toggles,");
        $display("input gaps, output stalls and a stretch of back-to-back traffic.");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb_fir_decimate_by_three: PASS");
        end else begin
            $display("tb_fir_decimate_by_three: FAIL");
        end
        $finish;
    end

endmodule
